[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the integral image block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define IIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define IIS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define IIS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/iis_pkg.sv]
// ----------------------------------------------------------------------------
// Integral image package
// Widths, defaults, register indexes and shared types of the integral image.
// ----------------------------------------------------------------------------
package iis_pkg;

  // Pixel and sum widths.
  localparam int PixelBits = 8;
  localparam int SqBits    = 2 * PixelBits;
  localparam int SumW      = 37;
  localparam int AreaW     = 36;

  // Configuration port.
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 11;

  // Frame geometry defaults; DimW covers the largest supported dimension.
  localparam int DefaultMaxWidth  = 1024;
  localparam int DefaultMaxHeight = 1024;
  localparam int ResetDim         = 1024;
  localparam int DimW             = 12;

  // Register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegSquareMode  = 2'd2
  } cfg_reg_e;

  // Clamped frame geometry and mode handed to the datapath.
  typedef struct packed {
    logic [DimW-1:0] last_col;
    logic [DimW-1:0] last_row;
    logic            square;
  } cfg_t;

endpackage

[rtl/iis_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module iis_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/iis_cfg.sv]
// ----------------------------------------------------------------------------
// Integral image configuration
// Register file that stores the frame geometry already clamped to its range.
// ----------------------------------------------------------------------------
module iis_cfg import iis_pkg::*; #(
  parameter int MaxImageWidth  = DefaultMaxWidth,
  parameter int MaxImageHeight = DefaultMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  localparam int ResetW = (ResetDim < MaxImageWidth) ? ResetDim : MaxImageWidth;
  localparam int ResetH = (ResetDim < MaxImageHeight) ? ResetDim : MaxImageHeight;

  logic [DimW-1:0] last_col_q, last_col_d;
  logic [DimW-1:0] last_row_q, last_row_d;
  logic            square_q, square_d;
  logic [DimW-1:0] clamp_w, clamp_h;

  // Zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    if (cfg_wdata_i == '0) begin
      clamp_w = '0;
    end else if (32'(cfg_wdata_i) > 32'(MaxImageWidth)) begin
      clamp_w = DimW'(MaxImageWidth - 1);
    end else begin
      clamp_w = DimW'(cfg_wdata_i - 1'b1);
    end
    if (cfg_wdata_i == '0) begin
      clamp_h = '0;
    end else if (32'(cfg_wdata_i) > 32'(MaxImageHeight)) begin
      clamp_h = DimW'(MaxImageHeight - 1);
    end else begin
      clamp_h = DimW'(cfg_wdata_i - 1'b1);
    end
  end

  // Register decode; unknown indexes are ignored.
  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    square_d   = square_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegImageWidth:  last_col_d = clamp_w;
        RegImageHeight: last_row_d = clamp_h;
        RegSquareMode:  square_d   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= DimW'(ResetW - 1);
      last_row_q <= DimW'(ResetH - 1);
      square_q   <= 1'b0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      square_q   <= square_d;
    end
  end

  assign cfg_o = '{last_col: last_col_q, last_row: last_row_q, square: square_q};

endmodule

[rtl/integral_image_stream.sv]
// ----------------------------------------------------------------------------
// Integral image stream
// Streaming summed-area table over grey pixels, or their squares, in raster order.
// ----------------------------------------------------------------------------
// The block gives one summed-area result per pixel, through the sum stage and
// the output register, in the same order. It takes one pixel per clock while
// the output is not stalled, a rate set by the row buffer RAM, which is read
// once when a pixel enters and written once when its result leaves the sum
// stage, with the previous result forwarded when both touch the same column.
// The row buffer needs no clearing pass after reset: row 0 ignores what it
// reads. An output register parts the two sides, so a stalled output holds
// up the input only once the sum stage is also full.
`include "assert_macros.svh"

module integral_image_stream import iis_pkg::*; #(
  parameter int MaxImageWidth  = DefaultMaxWidth,
  parameter int MaxImageHeight = DefaultMaxHeight
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // Pixel input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PixelBits-1:0] pixel_i,
  // Result output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AreaW-1:0]     area_sum_o,
  output logic                 row_end_o,
  output logic                 frame_end_o
);

  localparam int ColW = (MaxImageWidth > 1) ? $clog2(MaxImageWidth) : 1;
  localparam int RowW = (MaxImageHeight > 1) ? $clog2(MaxImageHeight) : 1;

  cfg_t cfg;

  // Position and running sum of the entry stage.
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [SumW-1:0] row_sum_q, row_sum_d;

  // Sum stage.
  logic            s1_valid_q, s1_valid_d;
  logic [SumW-1:0] s1_sum_q;
  logic [ColW-1:0] s1_col_q;
  logic            s1_rz_q, s1_row_end_q, s1_frame_end_q;
  logic            fwd_q;
  logic [SumW-1:0] fwd_data_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [AreaW-1:0] out_sum_q;
  logic             out_row_end_q, out_frame_end_q;

  logic             in_acc, s1_adv, out_acc;
  logic             last_col, last_row;
  logic [SqBits-1:0] pix_val;
  logic [SumW-1:0]  sum_new, above, area, rdata;

  iis_cfg #(
    .MaxImageWidth (MaxImageWidth),
    .MaxImageHeight(MaxImageHeight)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Handshake between the stages.
  assign out_acc    = out_valid_q && !out_stall_i;
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Entry stage: pixel value, row running sum and end-of-row decisions.
  assign pix_val  = cfg.square ? SqBits'(pixel_i) * SqBits'(pixel_i) : SqBits'(pixel_i);
  assign sum_new  = row_sum_q + SumW'(pix_val);
  assign last_col = DimW'(col_q) >= cfg.last_col;
  assign last_row = DimW'(row_q) >= cfg.last_row;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    row_sum_d = row_sum_q;
    if (in_acc) begin
      if (last_col) begin
        col_d     = '0;
        row_sum_d = '0;
        row_d     = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d     = col_q + 1'b1;
        row_sum_d = sum_new;
      end
    end
  end

  // Row buffer: read at entry, written back when the sum stage drains.
  iis_ram #(
    .Width(SumW),
    .Depth(MaxImageWidth)
  ) u_row_buf (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(area),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(rdata)
  );

  // Sum stage: add the buffered result above, taking a forwarded one if
  // the previous pixel wrote this column in the cycle it was read.
  always_comb begin
    if (s1_rz_q) begin
      above = '0;
    end else if (fwd_q) begin
      above = fwd_data_q;
    end else begin
      above = rdata;
    end
  end

  assign area = s1_sum_q + above;

  // Valid bits.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_acc) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      row_sum_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      row_sum_q   <= row_sum_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sum stage payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sum_q       <= sum_new;
      s1_col_q       <= col_q;
      s1_rz_q        <= (row_q == '0);
      s1_row_end_q   <= last_col;
      s1_frame_end_q <= last_col && last_row;
      fwd_q          <= s1_valid_q && (s1_col_q == col_q);
      fwd_data_q     <= area;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sum_q       <= area[AreaW-1:0];
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign area_sum_o  = out_sum_q;
  assign row_end_o   = out_row_end_q;
  assign frame_end_o = out_frame_end_q;

  // Checks.
  `IIS_ASSERT(a_frame_in_row, clk_i, rst_ni,
              out_valid_o |-> (!frame_end_o || row_end_o), "frame end without row end")
  `IIS_ASSERT_NEVER(a_stall_empty, clk_i, rst_ni,
                    in_stall_o && !s1_valid_q, "input stalled with empty sum stage")
  `IIS_ASSERT(a_accept_fill, clk_i, rst_ni,
              in_acc |=> s1_valid_q, "accepted beat lost before sum stage")
  `IIS_ASSERT(a_frame_wrap, clk_i, rst_ni,
              (in_acc && last_col && last_row) |=> (row_q == '0 && col_q == '0),
              "position not cleared at frame end")

endmodule
